>>> rtl/bcd_clock_field_setter_defines.svh
// Shared assertion macros for the clock field setter.
`ifndef BCD_CLOCK_FIELD_SETTER_DEFINES_SVH
`define BCD_CLOCK_FIELD_SETTER_DEFINES_SVH

// Concurrent check sampled on the rising clock edge, off while reset is asserted.
`define BCFS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Next-cycle check: the consequent must hold in the cycle after the trigger.
`define BCFS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bcdcfs_pkg.sv
package bcdcfs_pkg;

	typedef enum logic [1:0] {
		KIND_MODE = 2'd0,
		KIND_UP   = 2'd1,
		KIND_DOWN = 2'd2,
		KIND_LOAD = 2'd3
	} kind_t;

	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_SEC   = 3'd1;
	localparam logic [2:0] MODE_MIN   = 3'd2;
	localparam logic [2:0] MODE_HOUR  = 3'd3;
	localparam logic [2:0] MODE_DATE  = 3'd4;
	localparam logic [2:0] MODE_MONTH = 3'd5;
	localparam logic [2:0] MODE_YEAR  = 3'd6;
	localparam logic [2:0] MODE_WDAY  = 3'd7;

	localparam logic [7:0] MASK_SEC   = 8'h7f;
	localparam logic [7:0] MASK_HOUR  = 8'h3f;
	localparam logic [7:0] MASK_MONTH = 8'h1f;
	localparam logic [7:0] MASK_YEAR  = 8'hff;
	localparam logic [7:0] MASK_WDAY  = 8'h07;

	localparam logic [7:0] SEC_HI   = 8'h59;
	localparam logic [7:0] HOUR_HI  = 8'h23;
	localparam logic [7:0] DATE_HI  = 8'h31;
	localparam logic [7:0] MONTH_HI = 8'h12;
	localparam logic [7:0] YEAR_HI  = 8'h99;
	localparam logic [7:0] WDAY_HI  = 8'h07;
	localparam logic [7:0] LO_ZERO  = 8'h00;
	localparam logic [7:0] LO_ONE   = 8'h01;

	localparam logic [3:0] NIB_UP_FIX = 4'ha;
	localparam logic [3:0] NIB_DN_FIX = 4'hf;
	localparam logic [7:0] BCD_ADJ    = 8'd6;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] load_seconds;
		logic [6:0] load_minutes;
		logic [5:0] load_hours;
		logic [2:0] load_weekday;
		logic [5:0] load_date;
		logic [4:0] load_month;
		logic [7:0] load_year;
	} item_t;

	// One BCD step with wrap at the bounds; the nibble fix keeps digits decimal.
	function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] mask,
			input logic [7:0] lo, input logic [7:0] hi, input logic up);
		logic [7:0] t;
		t = v;
		if (up) begin
			if (v == hi) begin
				t = lo;
			end else begin
				t = (v + 8'd1) & mask;
				if (t[3:0] == NIB_UP_FIX) begin
					t = (t + BCD_ADJ) & mask;
				end
			end
		end else begin
			if (v == lo) begin
				t = hi;
			end else begin
				t = (v - 8'd1) & mask;
				if (t[3:0] == NIB_DN_FIX) begin
					t = (t - BCD_ADJ) & mask;
				end
			end
		end
		return t;
	endfunction

endpackage

>>> rtl/bcdcfs_in_stage.sv
module bcdcfs_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bcdcfs_pkg::item_t item,
	input  logic              advance,
	output logic              valid_s1,
	output bcdcfs_pkg::item_t item_s1
);

	logic load_en;

	// The stage can take a new transfer when it is empty or its item moves on.
	assign load_en  = !valid_s1 || advance;
	assign in_stall = !load_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

>>> rtl/bcdcfs_field_core.sv
module bcdcfs_field_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  bcdcfs_pkg::item_t item_s1,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        mode,
	output logic [6:0]        seconds,
	output logic [6:0]        minutes,
	output logic [5:0]        hours,
	output logic [2:0]        weekday,
	output logic [5:0]        date,
	output logic [4:0]        month,
	output logic [7:0]        year,
	output logic              write_back
);

	logic [2:0] mode_q;
	logic [6:0] sec_q;
	logic [6:0] min_q;
	logic [5:0] hour_q;
	logic [2:0] wday_q;
	logic [5:0] date_q;
	logic [4:0] month_q;
	logic [7:0] year_q;
	logic       wb_q;
	logic       out_valid_q;

	logic [2:0] mode_d;
	logic [6:0] sec_d;
	logic [6:0] min_d;
	logic [5:0] hour_d;
	logic [2:0] wday_d;
	logic [5:0] date_d;
	logic [4:0] month_d;
	logic [7:0] year_d;
	logic       wb_d;
	logic       up;

	logic [7:0] sec_step;
	logic [7:0] min_step;
	logic [7:0] hour_step;
	logic [7:0] date_step;
	logic [7:0] month_step;
	logic [7:0] year_step;
	logic [7:0] wday_step;

	// The field registers double as the result register: they only change when
	// the previous result has been taken, so a stalled result holds.
	assign advance = !out_valid_q || !out_stall;
	assign up      = (item_s1.kind == bcdcfs_pkg::KIND_UP);

	assign sec_step   = bcdcfs_pkg::bcd_step({1'b0, sec_q}, bcdcfs_pkg::MASK_SEC,
		bcdcfs_pkg::LO_ZERO, bcdcfs_pkg::SEC_HI, up);
	assign min_step   = bcdcfs_pkg::bcd_step({1'b0, min_q}, bcdcfs_pkg::MASK_SEC,
		bcdcfs_pkg::LO_ZERO, bcdcfs_pkg::SEC_HI, up);
	assign hour_step  = bcdcfs_pkg::bcd_step({2'b00, hour_q}, bcdcfs_pkg::MASK_HOUR,
		bcdcfs_pkg::LO_ZERO, bcdcfs_pkg::HOUR_HI, up);
	assign date_step  = bcdcfs_pkg::bcd_step({2'b00, date_q}, bcdcfs_pkg::MASK_HOUR,
		bcdcfs_pkg::LO_ONE, bcdcfs_pkg::DATE_HI, up);
	assign month_step = bcdcfs_pkg::bcd_step({3'b000, month_q}, bcdcfs_pkg::MASK_MONTH,
		bcdcfs_pkg::LO_ONE, bcdcfs_pkg::MONTH_HI, up);
	assign year_step  = bcdcfs_pkg::bcd_step(year_q, bcdcfs_pkg::MASK_YEAR,
		bcdcfs_pkg::LO_ZERO, bcdcfs_pkg::YEAR_HI, up);
	assign wday_step  = bcdcfs_pkg::bcd_step({5'b00000, wday_q}, bcdcfs_pkg::MASK_WDAY,
		bcdcfs_pkg::LO_ONE, bcdcfs_pkg::WDAY_HI, up);

	always_comb begin
		mode_d  = mode_q;
		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		wday_d  = wday_q;
		date_d  = date_q;
		month_d = month_q;
		year_d  = year_q;
		wb_d    = 1'b0;
		case (item_s1.kind)
			bcdcfs_pkg::KIND_MODE: begin
				mode_d = mode_q + 3'd1;
			end
			bcdcfs_pkg::KIND_LOAD: begin
				sec_d   = item_s1.load_seconds;
				min_d   = item_s1.load_minutes;
				hour_d  = item_s1.load_hours;
				wday_d  = item_s1.load_weekday;
				date_d  = item_s1.load_date;
				month_d = item_s1.load_month;
				year_d  = item_s1.load_year;
			end
			bcdcfs_pkg::KIND_UP, bcdcfs_pkg::KIND_DOWN: begin
				wb_d = 1'b1;
				case (mode_q)
					bcdcfs_pkg::MODE_SEC:   sec_d   = sec_step[6:0];
					bcdcfs_pkg::MODE_MIN:   min_d   = min_step[6:0];
					bcdcfs_pkg::MODE_HOUR:  hour_d  = hour_step[5:0];
					bcdcfs_pkg::MODE_DATE:  date_d  = date_step[5:0];
					bcdcfs_pkg::MODE_MONTH: month_d = month_step[4:0];
					bcdcfs_pkg::MODE_YEAR:  year_d  = year_step;
					bcdcfs_pkg::MODE_WDAY:  wday_d  = wday_step[2:0];
					default:                wb_d    = 1'b0;
				endcase
			end
			default: begin
				wb_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= bcdcfs_pkg::MODE_NONE;
			sec_q       <= 7'd0;
			min_q       <= 7'd0;
			hour_q      <= 6'd0;
			wday_q      <= 3'd1;
			date_q      <= 6'd1;
			month_q     <= 5'd1;
			year_q      <= 8'd0;
			wb_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				mode_q  <= mode_d;
				sec_q   <= sec_d;
				min_q   <= min_d;
				hour_q  <= hour_d;
				wday_q  <= wday_d;
				date_q  <= date_d;
				month_q <= month_d;
				year_q  <= year_d;
				wb_q    <= wb_d;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign mode       = mode_q;
	assign seconds    = sec_q;
	assign minutes    = min_q;
	assign hours      = hour_q;
	assign weekday    = wday_q;
	assign date       = date_q;
	assign month      = month_q;
	assign year       = year_q;
	assign write_back = wb_q;

endmodule

>>> rtl/bcd_clock_field_setter.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// input    | in_valid / in_stall | kind, load_seconds .. load_year
// output   | out_valid/out_stall | mode, seconds .. year, write_back
//
// One item per cycle when no result stalls; the input stage registers it first.
// The field registers are the result register, so one adjust per cycle is the limit.
// Reset clears the mode and loads the fields with 00:00:00, weekday 1, 01/01/00.
// A stalled result holds the fields; the input stage then fills and stalls the input.
module bcd_clock_field_setter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [6:0] load_seconds,
	input  logic [6:0] load_minutes,
	input  logic [5:0] load_hours,
	input  logic [2:0] load_weekday,
	input  logic [5:0] load_date,
	input  logic [4:0] load_month,
	input  logic [7:0] load_year,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] mode,
	output logic [6:0] seconds,
	output logic [6:0] minutes,
	output logic [5:0] hours,
	output logic [2:0] weekday,
	output logic [5:0] date,
	output logic [4:0] month,
	output logic [7:0] year,
	output logic       write_back
);

	bcdcfs_pkg::item_t item;
	bcdcfs_pkg::item_t item_s1;
	logic              valid_s1;
	logic              advance;

	always_comb begin
		item.kind         = bcdcfs_pkg::kind_t'(kind);
		item.load_seconds = load_seconds;
		item.load_minutes = load_minutes;
		item.load_hours   = load_hours;
		item.load_weekday = load_weekday;
		item.load_date    = load_date;
		item.load_month   = load_month;
		item.load_year    = load_year;
	end

	bcdcfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bcdcfs_field_core u_field_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mode       (mode),
		.seconds    (seconds),
		.minutes    (minutes),
		.hours      (hours),
		.weekday    (weekday),
		.date       (date),
		.month      (month),
		.year       (year),
		.write_back (write_back)
	);

endmodule

>>> rtl/bcdcfs_port_checker.sv
`include "bcd_clock_field_setter_defines.svh"

module bcdcfs_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic [6:0] load_seconds,
	input logic [6:0] load_minutes,
	input logic [5:0] load_hours,
	input logic [2:0] load_weekday,
	input logic [5:0] load_date,
	input logic [4:0] load_month,
	input logic [7:0] load_year,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] mode,
	input logic [6:0] seconds,
	input logic [6:0] minutes,
	input logic [5:0] hours,
	input logic [2:0] weekday,
	input logic [5:0] date,
	input logic [4:0] month,
	input logic [7:0] year,
	input logic       write_back
);

	// A result that is held back keeps its whole payload.
	`BCFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable({mode, seconds, minutes, hours, weekday, date, month, year,
		write_back}), "stalled result changed")

	// The input only stalls when a result is waiting and blocked.
	`BCFS_ASSERT(a_in_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall),
		"input stalled without a blocked result")

	// No field is adjusted while no field is selected.
	`BCFS_ASSERT(a_wb_mode, clk, arst_n,
		(out_valid && write_back) |-> (mode != bcdcfs_pkg::MODE_NONE),
		"write_back reported in mode zero")

	// Stepping the weekday never lands on zero, whatever was loaded.
	`BCFS_ASSERT(a_wday_step, clk, arst_n,
		(out_valid && write_back && (mode == bcdcfs_pkg::MODE_WDAY)) |-> (weekday != 3'd0),
		"weekday step produced zero")

endmodule

bind bcd_clock_field_setter bcdcfs_port_checker u_port_checker (.*);
